/* rtl/core/bmp24_pkg.sv */
// Shared types, codes and header layout constants for the BMP24 stream decoder.
// No dependencies; the design modules refer to this package by scoped names.
`timescale 1ns / 1ps

package bmp24_pkg;

    localparam int MAX_DIMENSION_DEF = 4096;

    // Header layout (byte positions within the file)
    localparam logic [5:0]  POS_SIG0      = 6'd0;
    localparam logic [5:0]  POS_SIG1      = 6'd1;
    localparam logic [5:0]  POS_OFFSET    = 6'd10;
    localparam logic [5:0]  POS_WIDTH     = 6'd18;
    localparam logic [5:0]  POS_HEIGHT    = 6'd22;
    localparam logic [5:0]  POS_DEPTH_LO  = 6'd28;
    localparam logic [5:0]  POS_DEPTH_HI  = 6'd29;
    localparam logic [5:0]  POS_COMP      = 6'd30;
    localparam logic [5:0]  POS_HDR_LAST  = 6'd53;

    // Precompute slots, after width and height are complete
    localparam logic [5:0]  POS_PRE_MAG   = 6'd26;
    localparam logic [5:0]  POS_PRE_PAD   = 6'd27;
    localparam logic [5:0]  POS_PRE_TOTAL = 6'd28;
    localparam logic [5:0]  POS_PRE_BASE  = 6'd29;

    localparam logic [31:0] HDR_BYTES     = 32'd54;
    localparam logic [7:0]  SIG_B         = 8'h42;
    localparam logic [7:0]  SIG_M         = 8'h4D;
    localparam logic [15:0] DEPTH_24      = 16'd24;

    localparam logic        KIND_PIXEL    = 1'b0;
    localparam logic        KIND_ERROR    = 1'b1;

    typedef enum logic [1:0] {
        ERR_NONE        = 2'd0,
        ERR_FORMAT      = 2'd1,
        ERR_UNSUPPORTED = 2'd2
    } err_t;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_HEADER = 3'd1,
        PH_SKIP   = 3'd2,
        PH_PIXEL  = 3'd3,
        PH_PAD    = 3'd4,
        PH_DONE   = 3'd5
    } phase_t;

    // Header summary handed from the header unit to the decode core
    typedef struct packed {
        err_t        code;       // verdict, valid while the last header byte is processed
        logic        flip;       // bottom-up file
        logic [31:0] offset;     // pixel data offset
        logic [23:0] base_init;  // row base of the first stored row when flipped
    } hdr_info_t;

    typedef struct packed {
        logic        result_kind;
        err_t        error_code;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [23:0] dest_index;
        logic        last_pixel;
        logic [12:0] image_width;
        logic [12:0] image_height;
    } result_t;

endpackage

/* rtl/core/bmp24_byte_if.sv */
// Input byte channel: valid/ready handshake with one file byte per transfer.
// Standalone; no package dependency.
`timescale 1ns / 1ps

interface bmp24_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       first_byte;

    modport source (output valid, output data_byte, output first_byte, input ready);
    modport sink   (input valid, input data_byte, input first_byte, output ready);
endinterface

/* rtl/core/bmp24_result_if.sv */
// Result channel: valid/ready handshake carrying one pixel or error report per transfer.
// Standalone; no package dependency.
`timescale 1ns / 1ps

interface bmp24_result_if;
    logic        valid;
    logic        ready;
    logic        result_kind;
    logic [1:0]  error_code;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [23:0] dest_index;
    logic        last_pixel;
    logic [12:0] image_width;
    logic [12:0] image_height;

    modport source (output valid, output result_kind, output error_code, output red,
                    output green, output blue, output dest_index, output last_pixel,
                    output image_width, output image_height, input ready);
    modport sink   (input valid, input result_kind, input error_code, input red,
                    input green, input blue, input dest_index, input last_pixel,
                    input image_width, input image_height, output ready);
endinterface

/* rtl/core/bmp24_cfg_if.sv */
// Configuration write channel: valid/ready handshake carrying the file length.
// Standalone; no package dependency.
`timescale 1ns / 1ps

interface bmp24_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/core/bmp24_stream_decoder_top.sv */
// BMP24 stream decoder, top level. A byte transfer is registered in the input register,
// decoded combinationally and its result (if any) is loaded into the result register.
// Throughput: one byte per cycle, set by the single decode step between the input
// register and the result register; it holds while results are taken each cycle.
// Reset (rst_n, async low) clears valid flags, the phase (idle) and all counters;
// file_length resets to zero.
// Depends on bmp24_pkg, the three channel interfaces, bmp24_header,
// bmp24_decode and bmp24_out_reg.
`timescale 1ns / 1ps

module bmp24_stream_decoder_top #(
    parameter int MAX_DIMENSION = bmp24_pkg::MAX_DIMENSION_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    bmp24_byte_if.sink       file_bytes,
    bmp24_result_if.source   pixels,
    bmp24_cfg_if.sink        cfg
);

    localparam int DIM_W = $clog2(MAX_DIMENSION + 1);

    // Input register stage
    logic        in_valid_reg, in_valid_next;
    logic [7:0]  in_byte_reg;
    logic        in_first_reg;
    logic        in_xfer;

    // Configuration: the user must write the file length only between files; the block does not enforce it
    logic [31:0] file_length_reg;

    // Pipeline control
    logic        advance;
    logic        out_free;

    // Core wiring
    bmp24_pkg::hdr_info_t hdr_info;
    logic [DIM_W-1:0]     img_width;
    logic [DIM_W-1:0]     img_height;
    logic                 hdr_capture;
    logic [5:0]           hdr_pos;
    logic                 has_result;
    bmp24_pkg::result_t   result;

    // A byte moves on when the result slot is free (or being emptied this
    // cycle); a new byte is taken whenever the input register empties.
    assign advance          = in_valid_reg && out_free;
    assign file_bytes.ready = !in_valid_reg || advance;
    assign in_xfer          = file_bytes.valid && file_bytes.ready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_xfer)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    // payload: no reset needed
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            in_byte_reg  <= file_bytes.data_byte;
            in_first_reg <= file_bytes.first_byte;
        end
    end

    // Config write channel is always ready
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            file_length_reg <= '0;
        end
        else if (cfg.valid)
        begin
            file_length_reg <= cfg.data;
        end
    end

    // Header capture, size precompute and verdict
    bmp24_header #(
        .MAX_DIMENSION (MAX_DIMENSION)
    ) u_header (
        .clk         (clk),
        .rst_n       (rst_n),
        .capture_en  (hdr_capture),
        .pos         (hdr_pos),
        .data_byte   (in_byte_reg),
        .file_length (file_length_reg),
        .info        (hdr_info),
        .width       (img_width),
        .height      (img_height)
    );

    // Phase sequencer and pixel assembly
    bmp24_decode #(
        .MAX_DIMENSION (MAX_DIMENSION)
    ) u_decode (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (advance),
        .data_byte   (in_byte_reg),
        .first_byte  (in_first_reg),
        .file_length (file_length_reg),
        .info        (hdr_info),
        .width       (img_width),
        .height      (img_height),
        .hdr_capture (hdr_capture),
        .hdr_pos     (hdr_pos),
        .has_result  (has_result),
        .result      (result)
    );

    // Result register toward the sink
    bmp24_out_reg u_out (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (advance && has_result),
        .d      (result),
        .free   (out_free),
        .pixels (pixels)
    );

endmodule

/* rtl/core/bmp24_header.sv */
// Header capture unit: collects the 54-byte header fields, precomputes the
// image size checks during the spare header bytes and issues the verdict.
// Depends on bmp24_pkg.
`timescale 1ns / 1ps

module bmp24_header #(
    parameter int  MAX_DIMENSION = bmp24_pkg::MAX_DIMENSION_DEF,
    localparam int DIM_W         = $clog2(MAX_DIMENSION + 1)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  capture_en,
    input  logic [5:0]            pos,
    input  logic [7:0]            data_byte,
    input  logic [31:0]           file_length,
    output bmp24_pkg::hdr_info_t  info,
    output logic [DIM_W-1:0]      width,
    output logic [DIM_W-1:0]      height
);

    localparam int          PAD_W   = DIM_W + 2;
    localparam int          TOT_W   = PAD_W + DIM_W;
    localparam int          PROD_W  = 2 * DIM_W;
    localparam int          SUM_W   = ((TOT_W > 32) ? TOT_W : 32) + 1;
    localparam logic [31:0] MAX_DIM = 32'(MAX_DIMENSION);

    logic              sig_ok_reg,   sig_ok_next;
    logic [31:0]       offset_reg,   offset_next;
    logic [31:0]       raw_w_reg,    raw_w_next;
    logic [31:0]       raw_h_reg,    raw_h_next;
    logic [15:0]       depth_reg,    depth_next;
    logic [31:0]       comp_reg,     comp_next;
    logic              w_bad_reg,    w_bad_next;
    logic              h_zero_reg,   h_zero_next;
    logic              dim_big_reg,  dim_big_next;
    logic [DIM_W-1:0]  width_reg,    width_next;
    logic [DIM_W-1:0]  height_reg,   height_next;
    logic [PAD_W-1:0]  padded_reg,   padded_next;
    logic [TOT_W-1:0]  total_reg,    total_next;
    logic [23:0]       base_reg,     base_next;

    logic [31:0]       h_mag;
    logic [PAD_W-1:0]  w_ext;
    logic [DIM_W-1:0]  h_minus1;
    logic [PROD_W-1:0] base_prod;
    logic [SUM_W-1:0]  end_sum;

    // little-endian byte lane insert for a 32-bit field starting at base
    function automatic logic [31:0] put_byte(input logic [31:0] f, input logic [5:0] p,
                                             input logic [5:0] base, input logic [7:0] b);
        logic [31:0] r;
        logic [5:0]  d;
        r = f;
        d = p - base;
        if (p >= base && d < 6'd4)
        begin
            r[{d[1:0], 3'b000} +: 8] = b;
        end
        return r;
    endfunction

    assign h_mag     = raw_h_reg[31] ? (~raw_h_reg + 32'd1) : raw_h_reg;
    assign w_ext     = PAD_W'(width_reg);
    assign h_minus1  = height_reg - DIM_W'(1);
    assign base_prod = PROD_W'(h_minus1) * PROD_W'(width_reg);

    always_comb
    begin
        sig_ok_next  = sig_ok_reg;
        offset_next  = offset_reg;
        raw_w_next   = raw_w_reg;
        raw_h_next   = raw_h_reg;
        depth_next   = depth_reg;
        comp_next    = comp_reg;
        w_bad_next   = w_bad_reg;
        h_zero_next  = h_zero_reg;
        dim_big_next = dim_big_reg;
        width_next   = width_reg;
        height_next  = height_reg;
        padded_next  = padded_reg;
        total_next   = total_reg;
        base_next    = base_reg;

        if (capture_en)
        begin
            if (pos == bmp24_pkg::POS_SIG0)
            begin
                // start of a new file: fields restart from zero
                sig_ok_next = (data_byte == bmp24_pkg::SIG_B);
                offset_next = '0;
                raw_w_next  = '0;
                raw_h_next  = '0;
                depth_next  = '0;
                comp_next   = '0;
            end
            else
            begin
                if (pos == bmp24_pkg::POS_SIG1)
                begin
                    sig_ok_next = sig_ok_reg && (data_byte == bmp24_pkg::SIG_M);
                end
                offset_next = put_byte(offset_reg, pos, bmp24_pkg::POS_OFFSET, data_byte);
                raw_w_next  = put_byte(raw_w_reg, pos, bmp24_pkg::POS_WIDTH, data_byte);
                raw_h_next  = put_byte(raw_h_reg, pos, bmp24_pkg::POS_HEIGHT, data_byte);
                comp_next   = put_byte(comp_reg, pos, bmp24_pkg::POS_COMP, data_byte);
                if (pos == bmp24_pkg::POS_DEPTH_LO)
                begin
                    depth_next[7:0] = data_byte;
                end
                if (pos == bmp24_pkg::POS_DEPTH_HI)
                begin
                    depth_next[15:8] = data_byte;
                end
            end

            // size arithmetic, one step per spare header byte
            if (pos == bmp24_pkg::POS_PRE_MAG)
            begin
                w_bad_next   = raw_w_reg[31] || (raw_w_reg == 32'd0);
                h_zero_next  = (h_mag == 32'd0);
                dim_big_next = (raw_w_reg > MAX_DIM) || (h_mag > MAX_DIM);
                width_next   = raw_w_reg[DIM_W-1:0];
                height_next  = h_mag[DIM_W-1:0];
            end
            if (pos == bmp24_pkg::POS_PRE_PAD)
            begin
                padded_next = ((w_ext << 1) + w_ext + PAD_W'(3)) & ~PAD_W'(3);
            end
            if (pos == bmp24_pkg::POS_PRE_TOTAL)
            begin
                total_next = TOT_W'(padded_reg) * TOT_W'(height_reg);
            end
            if (pos == bmp24_pkg::POS_PRE_BASE)
            begin
                base_next = 24'(base_prod);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sig_ok_reg  <= 1'b0;
            offset_reg  <= '0;
            raw_w_reg   <= '0;
            raw_h_reg   <= '0;
            depth_reg   <= '0;
            comp_reg    <= '0;
            w_bad_reg   <= 1'b0;
            h_zero_reg  <= 1'b0;
            dim_big_reg <= 1'b0;
            width_reg   <= '0;
            height_reg  <= '0;
            padded_reg  <= '0;
            total_reg   <= '0;
            base_reg    <= '0;
        end
        else
        begin
            sig_ok_reg  <= sig_ok_next;
            offset_reg  <= offset_next;
            raw_w_reg   <= raw_w_next;
            raw_h_reg   <= raw_h_next;
            depth_reg   <= depth_next;
            comp_reg    <= comp_next;
            w_bad_reg   <= w_bad_next;
            h_zero_reg  <= h_zero_next;
            dim_big_reg <= dim_big_next;
            width_reg   <= width_next;
            height_reg  <= height_next;
            padded_reg  <= padded_next;
            total_reg   <= total_next;
            base_reg    <= base_next;
        end
    end

    assign end_sum = SUM_W'(offset_reg) + SUM_W'(total_reg);

    // verdict, priority: signature and offset, then depth and compression, then dimensions, then file size
    always_comb
    begin
        if (!sig_ok_reg || (offset_reg >= file_length) || (offset_reg < bmp24_pkg::HDR_BYTES))
        begin
            info.code = bmp24_pkg::ERR_FORMAT;
        end
        else if ((comp_reg != 32'd0) || (depth_reg != bmp24_pkg::DEPTH_24))
        begin
            info.code = bmp24_pkg::ERR_UNSUPPORTED;
        end
        else if (w_bad_reg || h_zero_reg)
        begin
            info.code = bmp24_pkg::ERR_FORMAT;
        end
        else if (dim_big_reg)
        begin
            info.code = bmp24_pkg::ERR_UNSUPPORTED;
        end
        else if (end_sum > SUM_W'(file_length))
        begin
            info.code = bmp24_pkg::ERR_FORMAT;
        end
        else
        begin
            info.code = bmp24_pkg::ERR_NONE;
        end
    end

    assign info.flip      = ~raw_h_reg[31];
    assign info.offset    = offset_reg;
    assign info.base_init = base_reg;
    assign width          = width_reg;
    assign height         = height_reg;

endmodule

/* rtl/core/bmp24_decode.sv */
// Decode core: phase sequencer, byte position, pixel assembly, row/column
// counting and padding drop. Produces at most one result per byte.
// Depends on bmp24_pkg and the header summary from bmp24_header.
`timescale 1ns / 1ps

module bmp24_decode #(
    parameter int  MAX_DIMENSION = bmp24_pkg::MAX_DIMENSION_DEF,
    localparam int DIM_W         = $clog2(MAX_DIMENSION + 1)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  logic [7:0]            data_byte,
    input  logic                  first_byte,
    input  logic [31:0]           file_length,
    input  bmp24_pkg::hdr_info_t  info,
    input  logic [DIM_W-1:0]      width,
    input  logic [DIM_W-1:0]      height,
    output logic                  hdr_capture,
    output logic [5:0]            hdr_pos,
    output logic                  has_result,
    output bmp24_pkg::result_t    result
);

    bmp24_pkg::phase_t phase_reg, phase_next;
    logic [31:0]       pos_reg,   pos_next;
    logic [DIM_W-1:0]  row_reg,   row_next;
    logic [DIM_W-1:0]  col_reg,   col_next;
    logic [1:0]        bip_reg,   bip_next;
    logic [1:0]        pad_reg,   pad_next;
    logic [7:0]        blue_reg,  blue_next;
    logic [7:0]        green_reg, green_next;
    logic [23:0]       base_reg,  base_next;

    logic              do_pix;
    logic [DIM_W-1:0]  col_inc;
    logic [DIM_W-1:0]  row_inc;
    logic [1:0]        pad_dec;

    assign hdr_capture = step && (first_byte || (phase_reg == bmp24_pkg::PH_HEADER));
    assign hdr_pos     = first_byte ? 6'd0 : pos_reg[5:0];

    assign col_inc = col_reg + DIM_W'(1);
    assign row_inc = row_reg + DIM_W'(1);
    assign pad_dec = pad_reg - 2'd1;

    always_comb
    begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        bip_next   = bip_reg;
        pad_next   = pad_reg;
        blue_next  = blue_reg;
        green_next = green_reg;
        base_next  = base_reg;
        do_pix     = 1'b0;
        has_result = 1'b0;
        result     = '0;

        if (step)
        begin
            if (first_byte)
            begin
                pos_next   = 32'd1;
                row_next   = '0;
                col_next   = '0;
                bip_next   = '0;
                pad_next   = '0;
                blue_next  = '0;
                green_next = '0;
                base_next  = '0;
                if (file_length < bmp24_pkg::HDR_BYTES)
                begin
                    phase_next         = bmp24_pkg::PH_DONE;
                    has_result         = 1'b1;
                    result.result_kind = bmp24_pkg::KIND_ERROR;
                    result.error_code  = bmp24_pkg::ERR_FORMAT;
                end
                else
                begin
                    phase_next = bmp24_pkg::PH_HEADER;
                end
            end
            else
            begin
                case (phase_reg)
                    bmp24_pkg::PH_HEADER:
                    begin
                        pos_next = pos_reg + 32'd1;
                        if (pos_reg == 32'(bmp24_pkg::POS_HDR_LAST))
                        begin
                            if (info.code != bmp24_pkg::ERR_NONE)
                            begin
                                phase_next         = bmp24_pkg::PH_DONE;
                                has_result         = 1'b1;
                                result.result_kind = bmp24_pkg::KIND_ERROR;
                                result.error_code  = info.code;
                            end
                            else
                            begin
                                row_next  = '0;
                                col_next  = '0;
                                bip_next  = '0;
                                pad_next  = '0;
                                base_next = info.flip ? info.base_init : 24'd0;
                                phase_next = (info.offset == bmp24_pkg::HDR_BYTES) ?
                                             bmp24_pkg::PH_PIXEL : bmp24_pkg::PH_SKIP;
                            end
                        end
                    end
                    bmp24_pkg::PH_SKIP:
                    begin
                        pos_next = pos_reg + 32'd1;
                        if (pos_reg >= info.offset)
                        begin
                            phase_next = bmp24_pkg::PH_PIXEL;
                            do_pix     = 1'b1;
                        end
                    end
                    bmp24_pkg::PH_PIXEL:
                    begin
                        pos_next = pos_reg + 32'd1;
                        do_pix   = 1'b1;
                    end
                    bmp24_pkg::PH_PAD:
                    begin
                        pos_next = pos_reg + 32'd1;
                        pad_next = pad_dec;
                        if (pad_dec == 2'd0)
                        begin
                            phase_next = bmp24_pkg::PH_PIXEL;
                        end
                    end
                    default:
                    begin
                        // idle or finished: byte ignored, position holds
                    end
                endcase
            end

            if (do_pix)
            begin
                case (bip_reg)
                    2'd0:
                    begin
                        blue_next = data_byte;
                        bip_next  = 2'd1;
                    end
                    2'd1:
                    begin
                        green_next = data_byte;
                        bip_next   = 2'd2;
                    end
                    default:
                    begin
                        bip_next            = 2'd0;
                        has_result          = 1'b1;
                        result.result_kind  = bmp24_pkg::KIND_PIXEL;
                        result.error_code   = bmp24_pkg::ERR_NONE;
                        result.red          = data_byte;
                        result.green        = green_reg;
                        result.blue         = blue_reg;
                        result.dest_index   = base_reg + 24'(col_reg);
                        result.last_pixel   = (row_inc == height) && (col_inc == width);
                        result.image_width  = 13'(width);
                        result.image_height = 13'(height);
                        if (col_inc >= width)
                        begin
                            col_next = '0;
                            row_next = row_inc;
                            if (row_inc >= height)
                            begin
                                phase_next = bmp24_pkg::PH_DONE;
                            end
                            else
                            begin
                                // next destination row is one row up or down
                                base_next  = info.flip ? (base_reg - 24'(width))
                                                       : (base_reg + 24'(width));
                                pad_next   = width[1:0];
                                phase_next = (width[1:0] != 2'd0) ?
                                             bmp24_pkg::PH_PAD : bmp24_pkg::PH_PIXEL;
                            end
                        end
                        else
                        begin
                            col_next = col_inc;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= bmp24_pkg::PH_IDLE;
            pos_reg   <= '0;
            row_reg   <= '0;
            col_reg   <= '0;
            bip_reg   <= '0;
            pad_reg   <= '0;
            blue_reg  <= '0;
            green_reg <= '0;
            base_reg  <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            bip_reg   <= bip_next;
            pad_reg   <= pad_next;
            blue_reg  <= blue_next;
            green_reg <= green_next;
            base_reg  <= base_next;
        end
    end

endmodule

/* rtl/core/bmp24_out_reg.sv */
// Result register: holds one result until the downstream side takes it.
// Depends on bmp24_pkg and bmp24_result_if.
`timescale 1ns / 1ps

module bmp24_out_reg (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   load,
    input  bmp24_pkg::result_t     d,
    output logic                   free,
    bmp24_result_if.source         pixels
);

    logic               valid_reg, valid_next;
    bmp24_pkg::result_t res_reg;

    assign free = !valid_reg || pixels.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (pixels.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= d;
        end
    end

    assign pixels.valid        = valid_reg;
    assign pixels.result_kind  = res_reg.result_kind;
    assign pixels.error_code   = res_reg.error_code;
    assign pixels.red          = res_reg.red;
    assign pixels.green        = res_reg.green;
    assign pixels.blue         = res_reg.blue;
    assign pixels.dest_index   = res_reg.dest_index;
    assign pixels.last_pixel   = res_reg.last_pixel;
    assign pixels.image_width  = res_reg.image_width;
    assign pixels.image_height = res_reg.image_height;

endmodule
